FILE: rtl/bdlp_pkg.sv
package bdlp_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  typedef logic [1:0] press_event_t;

  localparam press_event_t EV_NONE  = 2'd0;
  localparam press_event_t EV_SHORT = 2'd1;
  localparam press_event_t EV_LONG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RESET = 16'd25;
  localparam logic [CFG_W-1:0] HOLD_TIME_RESET     = 16'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] hold_time;
  } cfg_t;

endpackage

FILE: rtl/bdlp_sample_if.sv
interface bdlp_sample_if;
  logic                          valid;
  logic                          ready;
  logic                          raw_level;
  logic [bdlp_pkg::TIME_W-1:0]   time_ms;

  modport source (output valid, output raw_level, output time_ms, input ready);
  modport sink (input valid, input raw_level, input time_ms, output ready);
endinterface

FILE: rtl/bdlp_result_if.sv
interface bdlp_result_if;
  logic                         valid;
  logic                         ready;
  bdlp_pkg::press_event_t       press_event;

  modport source (output valid, output press_event, input ready);
  modport sink (input valid, input press_event, output ready);
endinterface

FILE: rtl/button_debounce_long_press.sv
// Button debouncer with long-press detection. Each transaction on sample carries one
// active-low pin level and a wrapping millisecond timestamp and produces exactly one
// transaction on result: none, short press (on a debounced release after a press that
// was not reported long) or long hold (once, when a press lasts more than hold_time
// ms). The debounced level follows the raw level after it has been steady for more
// than debounce_time ms. Both times are set through the write port (index 0
// debounce_time, index 1 hold_time); the user must set them only while no
// transaction is in flight, which the block itself does not enforce. An input
// register feeds the decision logic, which writes an output register; one sample
// is taken per cycle and one transaction made per clock as long as result is taken.
module button_debounce_long_press (
  input  logic                             clk,
  input  logic                             rst,
  bdlp_sample_if.sink                      sample,
  bdlp_result_if.source                    result,
  input  logic                             cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]       cfg_data
);
  import bdlp_pkg::*;

  cfg_t              cfg;
  logic              s1_valid;
  logic              s1_level;
  logic [TIME_W-1:0] s1_time;
  logic              advance;
  press_event_t      core_event;
  logic              res_valid;
  press_event_t      res_event;

  assign advance = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_level <= sample.raw_level;
      s1_time <= sample.time_ms;
    end
  end

  bdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdlp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .commit      (advance),
    .level       (s1_level),
    .now         (s1_time),
    .press_event (core_event)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_event <= core_event;
    end
  end

  assign result.valid = res_valid;
  assign result.press_event = res_event;

endmodule

FILE: rtl/bdlp_cfg.sv
module bdlp_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]       cfg_data,
  output bdlp_pkg::cfg_t                   cfg
);
  import bdlp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time <= DEBOUNCE_TIME_RESET;
      cfg.hold_time <= HOLD_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME: cfg.debounce_time <= cfg_data;
        REG_HOLD_TIME:     cfg.hold_time <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/bdlp_core.sv
module bdlp_core (
  input  logic                           clk,
  input  logic                           rst,
  input  bdlp_pkg::cfg_t                 cfg,
  input  logic                           commit,
  input  logic                           level,
  input  logic [bdlp_pkg::TIME_W-1:0]    now,
  output bdlp_pkg::press_event_t         press_event
);
  import bdlp_pkg::*;

  logic              raw_prev;
  logic              stable_level;
  logic [TIME_W-1:0] change_stamp;
  logic [TIME_W-1:0] press_stamp;
  logic              press_armed;

  logic              raw_changed;
  logic [TIME_W-1:0] change_elapsed;
  logic [TIME_W-1:0] press_elapsed;
  logic              take;
  logic              press_now;
  logic              short_now;
  logic              long_now;

  assign raw_changed = (level != raw_prev);
  assign change_elapsed = raw_changed ? '0 : (now - change_stamp);
  assign press_elapsed = now - press_stamp;
  assign take = (change_elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_time})
                && (level != stable_level);
  assign press_now = take && !level;
  assign short_now = take && level && press_armed;
  // hold is only checked when the debounced level was already pressed
  assign long_now = !take && !stable_level && press_armed
                    && (press_elapsed > {{(TIME_W-CFG_W){1'b0}}, cfg.hold_time});

  always_comb begin
    press_event = EV_NONE;
    if (long_now) begin
      press_event = EV_LONG;
    end else if (short_now) begin
      press_event = EV_SHORT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev <= 1'b1;
      stable_level <= 1'b1;
      change_stamp <= '0;
      press_stamp <= '0;
      press_armed <= 1'b0;
    end else if (commit) begin
      raw_prev <= level;
      if (raw_changed) begin
        change_stamp <= now;
      end
      if (take) begin
        stable_level <= level;
      end
      if (press_now) begin
        press_stamp <= now;
        press_armed <= 1'b1;
      end else if (short_now || long_now) begin
        press_stamp <= '0;
        press_armed <= 1'b0;
      end
    end
  end

endmodule
